[rtl/core/lmfe_pkg.sv]
// Shared types, codes and constants for the LIN master frame engine.
package lmfe_pkg;

    localparam int MAX_DATA_DEF = 8;

    localparam logic [7:0]  BREAK_BITS_RST   = 8'd13;
    localparam logic [15:0] TIMEOUT_BITS_RST = 16'd19200;
    localparam logic [7:0]  SYNC_BYTE        = 8'h55;

    // APB register map, byte addresses
    localparam int          APB_AW        = 3;
    localparam logic [2:0]  ADDR_BREAK    = 3'd0;
    localparam logic [2:0]  ADDR_TIMEOUT  = 3'd4;

    typedef enum logic [2:0] {
        OP_TICK  = 3'd0,
        OP_WRITE = 3'd1,
        OP_START = 3'd2,
        OP_FETCH = 3'd3,
        OP_READ  = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ST_WAIT    = 2'd0,
        ST_OK      = 2'd1,
        ST_TIMEOUT = 2'd2,
        ST_NOQUERY = 2'd3
    } t_status;

    typedef struct packed {
        logic [2:0] op;
        logic       rx_level;
        logic [7:0] pid;
        logic [3:0] response_length;
        logic [3:0] data_length;
        logic       with_data;
        logic [3:0] byte_index;
        logic [7:0] data_byte;
    } t_item;

    typedef struct packed {
        logic       tx_level;
        logic       accepted;
        logic [1:0] status;
        logic [7:0] pid_out;
        logic [3:0] length_out;
        logic [7:0] byte_out;
    } t_result;

    typedef struct packed {
        logic [7:0]  break_bits;
        logic [15:0] timeout_bits;
    } t_cfg;

endpackage

[rtl/core/lin_master_frame_engine.sv]
// LIN master frame engine top level: stream request/result channels and APB registers.
//
// Requests enter on s_axis: tuser carries the operation (tick, write tx byte,
// start frame, fetch status, read buffer byte), tdata carries the operands.
// Every request produces exactly one result on m_axis with the bus tx level
// after that request, the start acknowledge, fetch status, current PID,
// received length and read-back byte.
// Path: a request first lands in one input register stage, then the engine
// update moves its result into the output register that drives m_axis.
// Throughput is one request per cycle while m_axis does not stall; each tick
// request is one bit time and the per-bit work sits between those two registers.
// If m_axis stalls, the output register holds its result, the input stage
// keeps one more request, and s_axis_tready then drops until m_axis drains.
// The APB port sets break length and response timeout; write it only while
// the engine is idle. Reset (synchronous, active low) empties both stages,
// puts the engine in idle with the line recessive and loads register defaults.
module lin_master_frame_engine import lmfe_pkg::*; #(
    parameter int MAX_DATA = MAX_DATA_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // request channel
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // [0] rx_level, [8:1] pid, [12:9] response_length, [16:13] data_length,
    // [17] with_data, [21:18] byte_index, [29:22] data_byte, [31:30] zero
    input  logic [31:0]       s_axis_tdata,
    // [2:0] op
    input  logic [2:0]        s_axis_tuser,
    // result channel
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // [0] tx_level, [1] accepted, [3:2] status, [11:4] pid_out,
    // [15:12] length_out, [23:16] byte_out
    output logic [23:0]       m_axis_tdata,
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic    r_in_vld;
    t_item   r_in_item;
    logic    r_out_vld;
    t_result r_out_res;
    t_result eng_res;
    t_cfg    cfg;
    logic    advance;
    logic    s_fire;

    assign advance       = r_in_vld & (~r_out_vld | m_axis_tready);
    assign s_axis_tready = ~r_in_vld | advance;
    assign s_fire        = s_axis_tvalid & s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (s_fire) begin
                r_in_vld <= 1'b1;
            end else if (advance) begin
                r_in_vld <= 1'b0;
            end
            if (advance) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_in_item.op              <= s_axis_tuser;
            r_in_item.rx_level        <= s_axis_tdata[0];
            r_in_item.pid             <= s_axis_tdata[8:1];
            r_in_item.response_length <= s_axis_tdata[12:9];
            r_in_item.data_length     <= s_axis_tdata[16:13];
            r_in_item.with_data       <= s_axis_tdata[17];
            r_in_item.byte_index      <= s_axis_tdata[21:18];
            r_in_item.data_byte       <= s_axis_tdata[29:22];
        end
        if (advance) begin
            r_out_res <= eng_res;
        end
    end

    lmfe_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    lmfe_engine #(
        .MAX_DATA (MAX_DATA)
    ) u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_item   (r_in_item),
        .i_cfg    (cfg),
        .o_result (eng_res)
    );

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {r_out_res.byte_out, r_out_res.length_out, r_out_res.pid_out,
                            r_out_res.status, r_out_res.accepted, r_out_res.tx_level};

endmodule

[rtl/core/lmfe_cfg_regs.sv]
// APB register block: break length and response timeout.
module lmfe_cfg_regs import lmfe_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    logic [7:0]  r_break_bits;
    logic [15:0] r_timeout_bits;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    // only paddr[2] selects; low address bits are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_break_bits   <= BREAK_BITS_RST;
            r_timeout_bits <= TIMEOUT_BITS_RST;
        end else if (wr_en) begin
            if (paddr[2] == ADDR_TIMEOUT[2]) begin
                r_timeout_bits <= pwdata[15:0];
            end else begin
                r_break_bits <= pwdata[7:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == ADDR_TIMEOUT[2]) begin
            prdata = {16'd0, r_timeout_bits};
        end else begin
            prdata = {24'd0, r_break_bits};
        end
    end

    assign o_cfg.break_bits   = r_break_bits;
    assign o_cfg.timeout_bits = r_timeout_bits;

endmodule

[rtl/core/lmfe_engine.sv]
// Frame sequencer and frame buffer: one request per cycle while i_fire is high, result is combinational.
module lmfe_engine import lmfe_pkg::*; #(
    parameter int MAX_DATA = MAX_DATA_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    localparam int         DEPTH   = MAX_DATA + 1;
    localparam int         AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [3:0] MAX_IDX = 4'(MAX_DATA);
    localparam logic [3:0] MAX_LEN = 4'(MAX_DATA + 1);

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_BREAK = 3'd1,
        PH_DATA  = 3'd2,
        PH_WAIT  = 3'd3,
        PH_RECV  = 3'd4,
        PH_DONE  = 3'd5,
        PH_TOUT  = 3'd6
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_bit_cnt, n_bit_cnt;
    logic [7:0]  r_shift, n_shift;
    logic [3:0]  r_ptr, n_ptr;
    logic [3:0]  r_flen, n_flen;
    logic [3:0]  r_exp, n_exp;
    logic [15:0] r_wait, n_wait;
    logic        r_line, n_line;
    logic [7:0]  r_pid, n_pid;

    // data bytes only; sync and PID positions live outside the array
    logic [7:0]  mem [DEPTH];
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [7:0]    mem_wd;

    logic [3:0]  ptr_inc;
    logic [3:0]  rd_sel;
    logic [3:0]  rd_off;
    logic [7:0]  tx_byte;
    logic [3:0]  rx_off;
    logic [7:0]  rx_shift;
    logic [7:0]  rx_cnt;
    logic [7:0]  rd_out;

    assign ptr_inc  = r_ptr + 4'd1;
    assign rx_shift = {i_item.rx_level, r_shift[7:1]};
    assign rx_cnt   = r_bit_cnt + 8'd1;
    assign rx_off   = r_ptr - 4'd2;

    // next transmit byte: current pointer on break end, next pointer after a stop bit
    assign rd_sel = (r_phase == PH_DATA) ? ptr_inc : r_ptr;
    assign rd_off = rd_sel - 4'd2;

    always_comb begin
        if (rd_sel == 4'd0) begin
            tx_byte = SYNC_BYTE;
        end else if (rd_sel == 4'd1) begin
            tx_byte = r_pid;
        end else if (rd_off <= MAX_IDX) begin
            tx_byte = mem[rd_off[AW-1:0]];
        end else begin
            tx_byte = 8'd0;
        end
    end

    assign rd_out = (i_item.byte_index <= MAX_IDX) ? mem[i_item.byte_index[AW-1:0]] : 8'd0;

    always_comb begin
        n_phase   = r_phase;
        n_bit_cnt = r_bit_cnt;
        n_shift   = r_shift;
        n_ptr     = r_ptr;
        n_flen    = r_flen;
        n_exp     = r_exp;
        n_wait    = r_wait;
        n_line    = r_line;
        n_pid     = r_pid;
        mem_we    = 1'b0;
        mem_wa    = '0;
        mem_wd    = '0;
        o_result  = '0;

        case (i_item.op)
            OP_TICK: begin
                case (r_phase)
                    PH_BREAK: begin
                        if (r_bit_cnt == 8'd0) begin
                            n_line = 1'b0;
                        end else if (r_bit_cnt == i_cfg.break_bits) begin
                            n_line = 1'b1;
                        end
                        if (r_bit_cnt >= i_cfg.break_bits) begin
                            n_phase   = PH_DATA;
                            n_bit_cnt = 8'd0;
                            n_shift   = tx_byte;
                        end else begin
                            n_bit_cnt = rx_cnt;
                        end
                    end
                    PH_DATA: begin
                        if (r_bit_cnt == 8'd0) begin
                            n_line = 1'b0;
                        end else if (r_bit_cnt < 8'd9) begin
                            n_line  = r_shift[0];
                            n_shift = {1'b0, r_shift[7:1]};
                        end else begin
                            n_line = 1'b1;
                        end
                        if (r_bit_cnt < 8'd9) begin
                            n_bit_cnt = rx_cnt;
                        end else begin
                            n_bit_cnt = 8'd0;
                            n_ptr     = ptr_inc;
                            if (ptr_inc >= r_flen) begin
                                if (r_exp == 4'd0) begin
                                    n_phase = PH_DONE;
                                end else begin
                                    n_ptr   = 4'd2;
                                    n_phase = PH_WAIT;
                                    n_wait  = 16'd0;
                                end
                            end else begin
                                n_shift = tx_byte;
                            end
                        end
                    end
                    PH_WAIT: begin
                        // a start bit wins over a timeout on the same tick
                        if (!i_item.rx_level) begin
                            n_phase   = PH_RECV;
                            n_bit_cnt = 8'd0;
                            n_shift   = 8'd0;
                        end else if (i_cfg.timeout_bits != 16'd0) begin
                            if (r_wait >= i_cfg.timeout_bits) begin
                                n_phase = PH_TOUT;
                            end else begin
                                n_wait = r_wait + 16'd1;
                            end
                        end
                    end
                    PH_RECV: begin
                        n_shift   = rx_shift;
                        n_bit_cnt = rx_cnt;
                        if (rx_cnt >= 8'd8) begin
                            n_bit_cnt = 8'd0;
                            if (rx_off <= MAX_IDX) begin
                                mem_we = 1'b1;
                                mem_wa = rx_off[AW-1:0];
                                mem_wd = rx_shift;
                            end
                            n_ptr = ptr_inc;
                            if (ptr_inc >= 4'd2 && (ptr_inc - 4'd2) < r_exp) begin
                                n_phase = PH_WAIT;
                                n_wait  = 16'd0;
                            end else begin
                                n_phase = PH_DONE;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            OP_WRITE: begin
                if (r_phase == PH_IDLE && i_item.byte_index <= MAX_IDX) begin
                    mem_we = 1'b1;
                    mem_wa = i_item.byte_index[AW-1:0];
                    mem_wd = i_item.data_byte;
                end
            end
            OP_START: begin
                if (r_phase == PH_IDLE && i_item.response_length <= MAX_LEN &&
                    i_item.data_length <= MAX_LEN) begin
                    o_result.accepted = 1'b1;
                    n_pid     = i_item.pid;
                    n_ptr     = 4'd0;
                    n_bit_cnt = 8'd0;
                    n_phase   = PH_BREAK;
                    if (i_item.with_data) begin
                        n_flen = 4'd2 + i_item.data_length;
                        n_exp  = 4'd0;
                    end else begin
                        n_flen = 4'd2;
                        n_exp  = i_item.response_length;
                    end
                end
            end
            OP_FETCH: begin
                case (r_phase)
                    PH_DONE: begin
                        o_result.status     = ST_OK;
                        o_result.length_out = r_exp;
                        n_phase             = PH_IDLE;
                    end
                    PH_TOUT: begin
                        o_result.status = ST_TIMEOUT;
                        n_phase         = PH_IDLE;
                    end
                    PH_IDLE: o_result.status = ST_NOQUERY;
                    default: o_result.status = ST_WAIT;
                endcase
            end
            OP_READ: begin
                o_result.byte_out = rd_out;
            end
            default: ;
        endcase

        o_result.tx_level = n_line;
        o_result.pid_out  = n_pid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_bit_cnt <= 8'd0;
            r_shift   <= 8'd0;
            r_ptr     <= 4'd0;
            r_flen    <= 4'd0;
            r_exp     <= 4'd0;
            r_wait    <= 16'd0;
            r_line    <= 1'b1;
            r_pid     <= 8'd0;
        end else if (i_fire) begin
            r_phase   <= n_phase;
            r_bit_cnt <= n_bit_cnt;
            r_shift   <= n_shift;
            r_ptr     <= n_ptr;
            r_flen    <= n_flen;
            r_exp     <= n_exp;
            r_wait    <= n_wait;
            r_line    <= n_line;
            r_pid     <= n_pid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire && mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
    end

endmodule
